// ===== hdl/rpo_pkg.sv =====
// Shared types, codes and constants for the RGB pixel operations block.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package rpo_pkg;

    // Port field widths are fixed by the interface.
    localparam int SAMPLE_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_ROW_WIDTH = 1024;
    localparam int DEF_SAMPLE_BITS   = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 2'd1;

    // Operation codes; the unused codes act as pass.
    localparam logic [2:0] OP_PASS      = 3'd0;
    localparam logic [2:0] OP_GRAY      = 3'd1;
    localparam logic [2:0] OP_NEG_BLUE  = 3'd2;
    localparam logic [2:0] OP_FLAT_RED  = 3'd3;
    localparam logic [2:0] OP_FLIP      = 3'd4;

    localparam logic [15:0] MAX_VALUE_RST = 16'd255;

    // Q16 luma weights, summing to exactly 65536.
    localparam logic [15:0] GRAY_WR = 16'd19595;
    localparam logic [15:0] GRAY_WG = 16'd38470;
    localparam logic [15:0] GRAY_WB = 16'd7471;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic                row_end;
        logic                drain;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] out_red;
        logic [SAMPLE_W-1:0] out_green;
        logic [SAMPLE_W-1:0] out_blue;
        logic                out_row_end;
    } out_item_t;

    // Read-side status from the line controller for one accepted item.
    typedef struct packed {
        logic hit;   // a stored pixel is given out
        logic last;  // it is the last pixel of the reversed row
    } rd_info_t;

endpackage

`default_nettype wire

// ===== hdl/rpo_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module rpo_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rpo_line_ctrl.sv =====
// Ping-pong line memory and its column counters for the horizontal flip.
// Depends on rpo_pkg and rpo_ram.
`default_nettype none

module rpo_line_ctrl #(
    parameter int MAX_ROW_WIDTH = rpo_pkg::DEF_MAX_ROW_WIDTH,
    parameter int SAMPLE_BITS   = rpo_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       acc,      // flip-mode item accepted
    input  wire logic                       drain,
    input  wire logic                       row_end,
    input  wire logic [3*SAMPLE_BITS-1:0]   wr_word,
    output rpo_pkg::rd_info_t               rd_info,
    output logic      [3*SAMPLE_BITS-1:0]   rd_word
);

    localparam int COL_W     = $clog2(MAX_ROW_WIDTH);
    localparam int CNT_W     = $clog2(MAX_ROW_WIDTH + 1);
    localparam int RAM_DEPTH = 2 * (1 << COL_W);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_ROW_WIDTH - 1);

    logic [COL_W-1:0] wcol_reg, wcol_next;
    logic [CNT_W-1:0] rrem_reg, rrem_next;
    logic             bank_reg, bank_next;
    logic [CNT_W-1:0] rrem_m1;
    logic             we, re;

    assign rrem_m1      = rrem_reg - CNT_W'(1);
    assign rd_info.hit  = (rrem_reg != '0);
    assign rd_info.last = (rrem_reg == CNT_W'(1));

    assign we = acc && !drain;
    assign re = acc && rd_info.hit;

    always_comb begin
        wcol_next = wcol_reg;
        rrem_next = rrem_reg;
        bank_next = bank_reg;
        if (re) begin
            rrem_next = rrem_m1;
        end
        if (we) begin
            if (row_end) begin
                // new row replaces whatever of the old one is still unread
                rrem_next = CNT_W'(wcol_reg) + CNT_W'(1);
                bank_next = !bank_reg;
                wcol_next = '0;
            end else if (wcol_reg != LAST_COL) begin
                wcol_next = wcol_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcol_reg <= '0;
            rrem_reg <= '0;
            bank_reg <= 1'b0;
        end else begin
            wcol_reg <= wcol_next;
            rrem_reg <= rrem_next;
            bank_reg <= bank_next;
        end
    end

    // Load bank and read bank always differ, so no same-entry overlap.
    rpo_ram #(
        .WIDTH (3 * SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr ({bank_reg, wcol_reg}),
        .wdata (wr_word),
        .re    (re),
        .raddr ({!bank_reg, rrem_m1[COL_W-1:0]}),
        .rdata (rd_word)
    );

    a_rrem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rrem_reg <= CNT_W'(MAX_ROW_WIDTH))
        else $error("read count beyond row width");

    a_row_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && row_end) |=> (rrem_reg == CNT_W'($past(wcol_reg)) + CNT_W'(1))
                            && (bank_reg != $past(bank_reg)) && (wcol_reg == '0))
        else $error("row end did not swap banks");

    a_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && re) |-> ({bank_reg, wcol_reg} != {!bank_reg, rrem_m1[COL_W-1:0]}))
        else $error("read and write on the same line entry");

endmodule

`default_nettype wire

// ===== hdl/rpo_color.sv =====
// Per-pixel colour operations: products and negation registered, luma sum after.
// Depends on rpo_pkg.
`default_nettype none

module rpo_color #(
    parameter int SAMPLE_BITS = rpo_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          ld,
    input  wire rpo_pkg::in_item_t             item,
    input  wire logic [2:0]                    operation,
    input  wire logic [rpo_pkg::CFG_DATA_W-1:0] max_value,
    output logic [rpo_pkg::SAMPLE_W-1:0]       pix_r,
    output logic [rpo_pkg::SAMPLE_W-1:0]       pix_g,
    output logic [rpo_pkg::SAMPLE_W-1:0]       pix_b
);

    localparam int PROD_W = SAMPLE_BITS + 16;
    localparam int SUM_W  = PROD_W + 2;

    logic [SAMPLE_BITS-1:0] r_m, g_m, b_m, m_m, b_diff;
    logic [SAMPLE_BITS-1:0] r_reg, g_reg, b_reg;
    logic [PROD_W-1:0]      pr_reg, pg_reg, pb_reg;
    logic                   gray_reg;
    logic [SUM_W-1:0]       sum;
    logic [SAMPLE_BITS-1:0] luma;

    assign r_m    = item.red[SAMPLE_BITS-1:0];
    assign g_m    = item.green[SAMPLE_BITS-1:0];
    assign b_m    = item.blue[SAMPLE_BITS-1:0];
    assign m_m    = max_value[SAMPLE_BITS-1:0];
    assign b_diff = (b_m >= m_m) ? (b_m - m_m) : (m_m - b_m);

    always_ff @(posedge aclk) begin
        if (ld) begin
            gray_reg <= (operation == rpo_pkg::OP_GRAY);
            pr_reg   <= PROD_W'(r_m) * PROD_W'(rpo_pkg::GRAY_WR);
            pg_reg   <= PROD_W'(g_m) * PROD_W'(rpo_pkg::GRAY_WG);
            pb_reg   <= PROD_W'(b_m) * PROD_W'(rpo_pkg::GRAY_WB);
            r_reg    <= (operation == rpo_pkg::OP_FLAT_RED) ? '0 : r_m;
            g_reg    <= g_m;
            b_reg    <= (operation == rpo_pkg::OP_NEG_BLUE) ? b_diff : b_m;
        end
    end

    assign sum  = SUM_W'(pr_reg) + SUM_W'(pg_reg) + SUM_W'(pb_reg);
    assign luma = sum[16 +: SAMPLE_BITS];

    assign pix_r = rpo_pkg::SAMPLE_W'(gray_reg ? luma : r_reg);
    assign pix_g = rpo_pkg::SAMPLE_W'(gray_reg ? luma : g_reg);
    assign pix_b = rpo_pkg::SAMPLE_W'(gray_reg ? luma : b_reg);

endmodule

`default_nettype wire

// ===== hdl/rgb_pixel_ops_with_row_flip_top.sv =====
// RGB pixel operations with horizontal row flip: an accepted item that gives a result
// passes stage 1 and then the output register, which raises m_valid (two register stages).
// Throughput one item per clock while s_ready is high, set by the line RAM (1 read + 1 write per clock);
// s_ready drops only while both stages are full and m_ready is low.
// Reset (aresetn, synchronous, active low) clears counters, bank, valids and configuration
// registers; data registers and line RAM content stay undefined, no clearing pass needed.
`default_nettype none

module rgb_pixel_ops_with_row_flip_top #(
    parameter int MAX_ROW_WIDTH = rpo_pkg::DEF_MAX_ROW_WIDTH,
    parameter int SAMPLE_BITS   = rpo_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [rpo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rpo_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire rpo_pkg::in_item_t              s_item,
    // result items
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output rpo_pkg::out_item_t                  m_item
);

    // ---- configuration registers
    logic [2:0]                     operation_reg;
    logic [rpo_pkg::CFG_DATA_W-1:0] max_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operation_reg <= rpo_pkg::OP_PASS;
            max_value_reg <= rpo_pkg::MAX_VALUE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rpo_pkg::REG_OPERATION: operation_reg <= cfg_wdata[2:0];
                rpo_pkg::REG_MAX_VALUE: max_value_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- handshake
    // Stage 1 holds an item only if it yields a result. It can take a new item
    // while the output register still waits, as long as stage 1 is free.
    logic v1_reg, v1_next;
    logic flip1_reg;     // stage-1 result comes from the line RAM
    logic end1_reg;      // row end of the stage-1 result
    logic m_valid_reg, m_valid_next;
    logic out_free, acc, is_flip, has_res, move1;
    rpo_pkg::out_item_t m_item_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !v1_reg || out_free;
    assign acc      = s_valid && s_ready;
    assign is_flip  = (operation_reg == rpo_pkg::OP_FLIP);
    assign move1    = v1_reg && out_free;

    // ---- line memory for flip mode
    rpo_pkg::rd_info_t          rd_info;
    logic [3*SAMPLE_BITS-1:0]   rd_word;
    logic [3*SAMPLE_BITS-1:0]   wr_word;

    assign wr_word = {s_item.blue[SAMPLE_BITS-1:0], s_item.green[SAMPLE_BITS-1:0],
                      s_item.red[SAMPLE_BITS-1:0]};

    rpo_line_ctrl #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .acc     (acc && is_flip),
        .drain   (s_item.drain),
        .row_end (s_item.row_end),
        .wr_word (wr_word),
        .rd_info (rd_info),
        .rd_word (rd_word)
    );

    // ---- colour operations for the other modes
    logic [rpo_pkg::SAMPLE_W-1:0] pix_r, pix_g, pix_b;

    rpo_color #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_color (
        .aclk      (aclk),
        .ld        (acc && !is_flip),
        .item      (s_item),
        .operation (operation_reg),
        .max_value (max_value_reg),
        .pix_r     (pix_r),
        .pix_g     (pix_g),
        .pix_b     (pix_b)
    );

    // A drain item gives a result only in flip mode with a row pending.
    assign has_res = is_flip ? rd_info.hit : !s_item.drain;

    always_comb begin
        v1_next = v1_reg;
        if (acc) begin
            v1_next = has_res;
        end else if (move1) begin
            v1_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (move1) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            flip1_reg <= is_flip;
            end1_reg  <= is_flip ? rd_info.last : s_item.row_end;
        end
        if (move1) begin
            if (flip1_reg) begin
                m_item_reg.out_red   <= rpo_pkg::SAMPLE_W'(rd_word[0 +: SAMPLE_BITS]);
                m_item_reg.out_green <= rpo_pkg::SAMPLE_W'(rd_word[SAMPLE_BITS +: SAMPLE_BITS]);
                m_item_reg.out_blue  <= rpo_pkg::SAMPLE_W'(rd_word[2*SAMPLE_BITS +: SAMPLE_BITS]);
            end else begin
                m_item_reg.out_red   <= pix_r;
                m_item_reg.out_green <= pix_g;
                m_item_reg.out_blue  <= pix_b;
            end
            m_item_reg.out_row_end <= end1_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ---- checks
    a_hold_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !out_free) |=> v1_reg)
        else $error("stage-1 item lost under back-pressure");

    a_move_out: assert property (@(posedge aclk) disable iff (!aresetn)
        move1 |=> m_valid_reg)
        else $error("stage-1 item did not reach the output register");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && v1_reg) |-> !s_ready)
        else $error("input taken with both stages full and stalled");

endmodule

`default_nettype wire

// ===== tb/rgb_pixel_ops_with_row_flip_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rgb_pixel_ops_with_row_flip_top: directed and random pixel
// items, a mirrored-row line model and per-field result checks. Depends on rpo_pkg and the RTL.

module rgb_pixel_ops_with_row_flip_top_tb;

    localparam int ROW_W = rpo_pkg::DEF_MAX_ROW_WIDTH;
    // Generous ceiling: ~2000 items, plus pauses per mode change.
    localparam int CYCLE_LIMIT = 200000;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [rpo_pkg::CFG_IDX_W-1:0]  cfg_index = rpo_pkg::REG_OPERATION;
    logic [rpo_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    rpo_pkg::in_item_t              s_item    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    rpo_pkg::out_item_t             m_item;

    int send_idle_pct  = 10;
    int recv_stall_pct = 57;
    int items_sent     = 0;
    int cycle_count    = 0;

    // Expected pixels: pixel ops for the plain modes, a two-bank line copy for the flip.
    class pixel_result_board;
        logic [47:0]         line_mem [2*ROW_W];
        int unsigned         wr_col;
        int unsigned         rd_left;
        bit                  bank;
        logic [2:0]          op;
        logic [15:0]         max_val;
        rpo_pkg::out_item_t  awaited_pixels[$];
        int                  errors;

        function new();
            wr_col  = 0;
            rd_left = 0;
            bank    = 1'b0;
            op      = rpo_pkg::OP_PASS;
            max_val = rpo_pkg::MAX_VALUE_RST;
            errors  = 0;
        endfunction

        function void set_reg(logic [rpo_pkg::CFG_IDX_W-1:0] idx,
                              logic [rpo_pkg::CFG_DATA_W-1:0] data);
            if (idx == rpo_pkg::REG_OPERATION) op = data[2:0];
            else if (idx == rpo_pkg::REG_MAX_VALUE) max_val = data;
        endfunction

        function int pending();
            return awaited_pixels.size();
        endfunction

        // Next pixel of the stored row, last column first.
        function bit next_mirrored_pixel(output rpo_pkg::out_item_t px);
            logic [47:0] word;
            px = '0;
            if (rd_left == 0) return 1'b0;
            rd_left = rd_left - 1;
            word = line_mem[(bank ? 0 : ROW_W) + rd_left];
            px.out_red     = word[15:0];
            px.out_green   = word[31:16];
            px.out_blue    = word[47:32];
            px.out_row_end = (rd_left == 0);
            return 1'b1;
        endfunction

        function void note_pixel_in(rpo_pkg::in_item_t it);
            rpo_pkg::out_item_t px;
            logic [47:0]        luma;
            if (op == rpo_pkg::OP_FLIP) begin
                if (!it.drain) begin
                    line_mem[(bank ? ROW_W : 0) + wr_col] = {it.blue, it.green, it.red};
                end
                if (next_mirrored_pixel(px)) awaited_pixels = {awaited_pixels, px};
                if (it.drain) return;
                // row end swaps banks; an unread remainder of the old row is lost
                if (it.row_end) begin
                    rd_left = wr_col + 1;
                    bank    = ~bank;
                    wr_col  = 0;
                end else if (wr_col + 1 < ROW_W) begin
                    wr_col++;
                end
                return;
            end
            if (it.drain) return;
            px.out_red     = it.red;
            px.out_green   = it.green;
            px.out_blue    = it.blue;
            px.out_row_end = it.row_end;
            case (op)
                rpo_pkg::OP_GRAY: begin
                    luma = it.red * rpo_pkg::GRAY_WR + it.green * rpo_pkg::GRAY_WG
                         + it.blue * rpo_pkg::GRAY_WB;
                    px.out_red   = luma[31:16];
                    px.out_green = luma[31:16];
                    px.out_blue  = luma[31:16];
                end
                rpo_pkg::OP_NEG_BLUE: begin
                    px.out_blue = (it.blue >= max_val) ? it.blue - max_val : max_val - it.blue;
                end
                rpo_pkg::OP_FLAT_RED: begin
                    px.out_red = '0;
                end
                default: ;
            endcase
            awaited_pixels = {awaited_pixels, px};
        endfunction

        function void check_pixel_out(rpo_pkg::out_item_t got);
            rpo_pkg::out_item_t want;
            if (awaited_pixels.size() == 0) begin
                $error("unexpected result item %h", got);
                errors++;
                return;
            end
            want = awaited_pixels.pop_front();
            if (got.out_red !== want.out_red) begin
                $error("out_red: expected %0d, actual %0d", want.out_red, got.out_red);
                errors++;
            end
            if (got.out_green !== want.out_green) begin
                $error("out_green: expected %0d, actual %0d", want.out_green, got.out_green);
                errors++;
            end
            if (got.out_blue !== want.out_blue) begin
                $error("out_blue: expected %0d, actual %0d", want.out_blue, got.out_blue);
                errors++;
            end
            if (got.out_row_end !== want.out_row_end) begin
                $error("out_row_end: expected %0d, actual %0d",
                       want.out_row_end, got.out_row_end);
                errors++;
            end
        endfunction
    endclass

    pixel_result_board board = new();

    rgb_pixel_ops_with_row_flip_top #(
        .MAX_ROW_WIDTH (ROW_W),
        .SAMPLE_BITS   (rpo_pkg::DEF_SAMPLE_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Everything is driven by NBA at the edge, so reads here see pre-edge values.
    // Inputs are noted before results so a same-edge result could still find its expectation.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) board.note_pixel_in(s_item);
        if (aresetn && m_valid && m_ready) board.check_pixel_out(m_item);
    end

    // Receiver back-pressure; a zero percentage leaves ready high throughout.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: a hang or a lost result ends up here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic rpo_pkg::in_item_t make_pixel(logic [15:0] r, logic [15:0] g,
                                                     logic [15:0] b, logic row_end,
                                                     logic drain);
        rpo_pkg::in_item_t it;
        it.red     = r;
        it.green   = g;
        it.blue    = b;
        it.row_end = row_end;
        it.drain   = drain;
        return it;
    endfunction

    // Samples weighted towards the extremes.
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Drain item with junk in every other field, which must be ignored.
    function automatic rpo_pkg::in_item_t noise_drain();
        return make_pixel(16'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom_range(0, 1)), 1'b1);
    endfunction

    // One item through the handshake. Valid is only dropped for idle cycles, never
    // dropped and raised in the same step.
    task automatic push_item(input rpo_pkg::in_item_t it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        // drains outside flip mode are ignored by the block
        if (!(it.drain && board.op != rpo_pkg::OP_FLIP)) items_sent++;
    endtask

    // Registers change only with nothing in flight: all results home, then the
    // pipeline latency again for items that gave none.
    task automatic program_block(input logic [2:0] op, input logic [15:0] maxv);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= rpo_pkg::REG_OPERATION;
        cfg_wdata <= {13'd0, op};
        @(posedge aclk);
        board.set_reg(rpo_pkg::REG_OPERATION, {13'd0, op});
        cfg_index <= rpo_pkg::REG_MAX_VALUE;
        cfg_wdata <= maxv;
        @(posedge aclk);
        board.set_reg(rpo_pkg::REG_MAX_VALUE, maxv);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic plain_pixels(input int quota);
        int k;
        for (k = 0; k < quota; k++) begin
            if ($urandom_range(0, 9) == 0) push_item(noise_drain());
            else push_item(make_pixel(rand_sample(), rand_sample(), rand_sample(),
                                      $urandom_range(0, 3) == 0, 1'b0));
        end
    endtask

    // Mostly whole rows of random width; some stray drains, early row ends and rows
    // left unfinished when the mode changes.
    task automatic flip_rows(input int quota);
        int start;
        int width;
        int k;
        start = items_sent;
        while (items_sent - start < quota) begin
            width = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            for (k = 0; k < width; k++) begin
                if ($urandom_range(0, 19) == 0) push_item(noise_drain());
                push_item(make_pixel(rand_sample(), rand_sample(), rand_sample(),
                                     (k == width - 1) || ($urandom_range(0, 29) == 0), 1'b0));
                if (items_sent - start >= quota && $urandom_range(0, 3) == 0) break;
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, width)) push_item(noise_drain());
            end
        end
        // half the time empty the stored row, otherwise leave it for a later flip segment
        if ($urandom_range(0, 1) == 0) begin
            repeat (board.rd_left + $urandom_range(0, 2)) push_item(noise_drain());
        end
    endtask

    function automatic logic [15:0] pick_max_value();
        case ($urandom_range(0, 4))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return rpo_pkg::MAX_VALUE_RST;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [2:0] pick_operation();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return rpo_pkg::OP_FLIP;
            4:          return rpo_pkg::OP_PASS;
            5:          return rpo_pkg::OP_GRAY;
            6:          return rpo_pkg::OP_NEG_BLUE;
            7:          return rpo_pkg::OP_FLAT_RED;
            8:          return rpo_pkg::OP_NEG_BLUE;
            default:    return 3'($urandom_range(5, 7));  // unused codes, expected to pass
        endcase
    endfunction

    initial begin
        int phase;
        int target;
        int k;
        int row_len;
        logic [2:0] op;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: pass, including a drain that must give nothing
        program_block(rpo_pkg::OP_PASS, rpo_pkg::MAX_VALUE_RST);
        push_item(make_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
        push_item(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
        push_item(make_pixel(16'h1234, 16'hABCD, 16'h5A5A, 1'b1, 1'b1));

        // grayscale extremes and each weight alone
        program_block(rpo_pkg::OP_GRAY, rpo_pkg::MAX_VALUE_RST);
        push_item(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
        push_item(make_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
        push_item(make_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0));
        push_item(make_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
        push_item(make_pixel(16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b0));

        // negate blue on both sides of max_value, and max_value at its extremes
        program_block(rpo_pkg::OP_NEG_BLUE, rpo_pkg::MAX_VALUE_RST);
        push_item(make_pixel(16'h0101, 16'h0202, 16'h0000, 1'b0, 1'b0));
        push_item(make_pixel(16'h0101, 16'h0202, 16'hFFFF, 1'b1, 1'b0));
        program_block(rpo_pkg::OP_NEG_BLUE, 16'hFFFF);
        push_item(make_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0));
        program_block(rpo_pkg::OP_NEG_BLUE, 16'd1);
        push_item(make_pixel(16'h0000, 16'hFFFF, 16'h0001, 1'b1, 1'b0));

        program_block(rpo_pkg::OP_FLAT_RED, rpo_pkg::MAX_VALUE_RST);
        push_item(make_pixel(16'hFFFF, 16'h1234, 16'h5678, 1'b1, 1'b0));

        // unused operation codes behave as pass
        for (k = 5; k <= 7; k++) begin
            program_block(3'(k), rpo_pkg::MAX_VALUE_RST);
            push_item(make_pixel(16'hFFFF, 16'h8001, 16'h7FFE, 1'(k & 1), 1'b0));
        end

        // flip: a row of three, then a row of two ending before the first is read out,
        // then drains past the end of the stored row
        program_block(rpo_pkg::OP_FLIP, rpo_pkg::MAX_VALUE_RST);
        push_item(make_pixel(16'h0001, 16'h0002, 16'h0003, 1'b0, 1'b0));
        push_item(make_pixel(16'h0011, 16'h0012, 16'h0013, 1'b0, 1'b0));
        push_item(make_pixel(16'h0021, 16'h0022, 16'h0023, 1'b1, 1'b0));
        push_item(make_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
        push_item(make_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b0));
        repeat (3) push_item(noise_drain());

        // Random: sender idles 10%/receiver 57%, then swapped, then no idling at all
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 10 : (phase == 1) ? 57 : 0;
            recv_stall_pct = (phase == 0) ? 57 : (phase == 1) ? 10 : 0;
            if (phase == 2) begin
                // over-long row: the overwritten last column comes out first, then a
                // one-pixel row replaces the unread remainder and is drained
                program_block(rpo_pkg::OP_FLIP, pick_max_value());
                row_len = ROW_W + $urandom_range(1, 12);
                for (k = 0; k < row_len; k++) begin
                    push_item(make_pixel(rand_sample(), rand_sample(), rand_sample(),
                                         k == row_len - 1, 1'b0));
                end
                repeat (8) push_item(noise_drain());
                push_item(make_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b1, 1'b0));
                push_item(noise_drain());
            end
            target = items_sent + 260;
            while (items_sent < target) begin
                op = pick_operation();
                program_block(op, pick_max_value());
                if (op == rpo_pkg::OP_FLIP) flip_rows($urandom_range(20, 60));
                else plain_pixels($urandom_range(10, 40));
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
